// ----- hw/rtl/bmh_pkg.sv -----
`timescale 1ns / 1ps

package bmh_pkg;

    // Operation codes carried in the op field of a command item.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHANGE = 2'd2
    } bmh_op_t;

    // Status codes reported with every result item.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } bmh_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REM_WAIT,
        S_CHG_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT
    } bmh_state_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic [6:0]         index;
    } bmh_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_key;
        logic signed [31:0] top_key;
        logic [7:0]         count;
    } bmh_result_t;

endpackage

// ----- hw/rtl/binary_max_heap_priority_queue.sv -----
`timescale 1ns / 1ps

// Channel   Signals              Direction  Transfer
// command   start, cmd           in         start high while busy is low
// result    done, result         out        done high for one cycle, always taken
//
// One command item is worked on at a time; busy stays high from the cycle after
// acceptance until the result cycle. Each heap level visited by a sift passes
// through a read state and a compare state, as the heap RAM has registered read
// data. rst_n clears the entry count and the controller; the heap RAM itself is
// never cleared, since only entries below the count are read.
// The receiver cannot stall: each result is presented exactly once.

module binary_max_heap_priority_queue
    import bmh_pkg::*;
#(
    parameter int CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  bmh_cmd_t    cmd,
    output logic        busy,
    output logic        done,
    output bmh_result_t result
);

    // AW addresses the heap RAM, CW holds a count from 0 to CAPACITY, and PW holds
    // a left child position (2*pos+1) before it has been range checked.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = AW + 1;
    localparam int XW = (CW > 7) ? CW : 7;

    bmh_state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic signed [31:0] mkey_reg, mkey_next;
    logic signed [31:0] removed_reg, removed_next;
    bmh_status_t        status_reg, status_next;

    // Heap RAM interface.
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic signed [31:0] rdata_a, rdata_b;

    // Tree navigation from the current hole position.
    logic [AW-1:0]      parent;
    logic [PW-1:0]      child_l, child_r, count_ext;
    logic               has_left, has_right, pick_right;
    logic signed [31:0] child_key;
    logic [AW-1:0]      child_pos;

    bmh_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // The moving key is kept in mkey_reg rather than swapped through the RAM:
    // each level writes the displaced neighbor into the hole, and the key itself
    // is written once where the sift stops. The final memory image equals that of
    // a swap-based sift. Reads always target the next level while the write goes
    // to the current one, so no read whose data is used meets a write to the same entry.
    assign parent     = (pos_reg - AW'(1)) >> 1;
    assign child_l    = {pos_reg, 1'b1};
    assign child_r    = child_l + PW'(1);
    assign count_ext  = PW'(count_reg);
    assign has_left   = child_l < count_ext;
    assign has_right  = child_r < count_ext;
    // On equal children the left one wins.
    assign pick_right = has_right && (rdata_b > rdata_a);
    assign child_key  = pick_right ? rdata_b : rdata_a;
    assign child_pos  = pick_right ? AW'(child_r) : AW'(child_l);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        mkey_reg    <= mkey_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        mkey_next    = mkey_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        we           = 1'b0;
        waddr        = pos_reg;
        wdata        = mkey_reg;
        raddr_a      = '0;
        raddr_b      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next  = ST_OK;
                    removed_next = '0;
                    mkey_next    = cmd.key;
                    state_next   = S_TOP_RD;
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                // Fetch the root and the last entry together.
                                raddr_a    = '0;
                                raddr_b    = AW'(count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_REM_WAIT;
                            end
                        end
                        OP_CHANGE:
                        begin
                            if (XW'(cmd.index) >= XW'(count_reg))
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                raddr_a    = AW'(cmd.index);
                                pos_next   = AW'(cmd.index);
                                state_next = S_CHG_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end

            S_REM_WAIT:
            begin
                removed_next = rdata_a;
                mkey_next    = rdata_b;
                pos_next     = '0;
                state_next   = S_DN_RD;
            end

            S_CHG_WAIT:
            begin
                // A larger key can only move toward the root; otherwise sift down.
                state_next = (mkey_reg > rdata_a) ? S_UP_RD : S_DN_RD;
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    raddr_a    = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                we = 1'b1;
                if (mkey_reg > rdata_a)
                begin
                    wdata      = rdata_a;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end

            S_DN_RD:
            begin
                if (!has_left)
                begin
                    we         = 1'b1;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    raddr_a    = AW'(child_l);
                    raddr_b    = has_right ? AW'(child_r) : AW'(child_l);
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                we = 1'b1;
                if (child_key > mkey_reg)
                begin
                    wdata      = child_key;
                    pos_next   = child_pos;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end

            S_TOP_RD:
            begin
                // Any write from the sift has already landed, so the root read here is current.
                raddr_a    = '0;
                state_next = S_TOP_WAIT;
            end

            S_TOP_WAIT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_TOP_WAIT);

    assign result.status      = status_reg;
    assign result.removed_key = removed_reg;
    assign result.top_key     = (count_reg != '0) ? rdata_a : 32'sd0;
    assign result.count       = 8'(count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_INSERT && count_reg != CW'(CAPACITY))
        |=> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("accepted insert did not grow the heap by one");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_CMP) |-> (pos_reg != '0))
        else $error("sift up compared the root against a parent");

    a_removed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_OK) |-> (removed_reg == 32'sd0))
        else $error("failed command reported a removed key");
`endif

endmodule

// ----- hw/rtl/bmh_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-read RAM: one write port, two read ports, registered read data.
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bmh_pkg::*;

    localparam int CAPACITY = 128;

    // Op code three carries no operation. The block answers it with an OK status
    // and leaves the heap alone.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // The run is stopped and failed when the cycle counter reaches this limit.
    localparam int CYCLE_LIMIT = 200000;

    // The tail is there to catch a stray result after the last expected one has come.
    localparam int TAIL_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    bmh_cmd_t    cmd = '0;
    logic        busy;
    logic        done;
    bmh_result_t result;

    // Shadow copy of the heap. It is updated once for every accepted item, so it
    // always holds what the block should hold after that item.
    logic signed [31:0] shadow_heap [CAPACITY];
    int unsigned        shadow_size = 0;

    // Results still owed by the block, oldest first.
    bmh_result_t awaited_replies [$];

    int sender_idle_pct = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int replies_checked = 0;
    int ops_sent [4] = '{0, 0, 0, 0};
    int statuses_seen [4] = '{0, 0, 0, 0};

    binary_max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run must end on its own well before this; a hang is a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, awaited_replies.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Moves the entry at pos toward the root while it beats its parent. Equal
    // keys never swap.
    function automatic void heap_sift_up(input int unsigned pos);
        int unsigned        parent;
        logic signed [31:0] held;
        while (pos > 0 && pos < shadow_size)
        begin
            parent = (pos - 1) / 2;
            if (shadow_heap[pos] <= shadow_heap[parent])
            begin
                break;
            end
            held = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[parent];
            shadow_heap[parent] = held;
            pos = parent;
        end
    endfunction

    // Moves the entry at pos toward the leaves. The right child is taken only
    // when it is strictly larger than the left one, and a child equal to its
    // parent is left in place.
    function automatic void heap_sift_down(input int unsigned pos);
        int unsigned        child;
        logic signed [31:0] held;
        while (pos < shadow_size)
        begin
            child = 2 * pos + 1;
            if (child >= shadow_size)
            begin
                break;
            end
            if (child + 1 < shadow_size && shadow_heap[child + 1] > shadow_heap[child])
            begin
                child++;
            end
            if (shadow_heap[child] <= shadow_heap[pos])
            begin
                break;
            end
            held = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[child];
            shadow_heap[child] = held;
            pos = child;
        end
    endfunction

    // Applies one command to the shadow heap and returns the result the block
    // must report for it. A rejected command leaves the shadow heap untouched.
    function automatic bmh_result_t apply_heap_cmd(input bmh_cmd_t c);
        bmh_result_t        r;
        logic signed [31:0] prior;
        r = '0;
        r.status = ST_OK;
        case (c.op)
            OP_INSERT:
            begin
                if (shadow_size >= CAPACITY)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    shadow_heap[shadow_size] = c.key;
                    shadow_size++;
                    heap_sift_up(shadow_size - 1);
                end
            end
            OP_REMOVE:
            begin
                if (shadow_size == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    r.removed_key = shadow_heap[0];
                    shadow_size--;
                    shadow_heap[0] = shadow_heap[shadow_size];
                    heap_sift_down(0);
                end
            end
            OP_CHANGE:
            begin
                if (c.index >= shadow_size)
                begin
                    r.status = ST_BAD_INDEX;
                end
                else
                begin
                    prior = shadow_heap[c.index];
                    shadow_heap[c.index] = c.key;
                    if (c.key > prior)
                    begin
                        heap_sift_up(c.index);
                    end
                    else
                    begin
                        heap_sift_down(c.index);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.top_key = (shadow_size > 0) ? shadow_heap[0] : 32'sd0;
        r.count = 8'(shadow_size);
        return r;
    endfunction

    // Keys lean on the extremes and on a narrow band around zero, so that equal
    // keys are common and the tie rules of both sift directions get exercised.
    function automatic logic signed [31:0] rand_key();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return int'($urandom_range(8)) - 4;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item and returns at the clock edge that accepts it. The start
    // line is left high, so a following call at the same edge keeps the item
    // stream back to back; only an idle gap or hold_until_drained lowers it.
    task automatic send_cmd(input logic [1:0] op, input logic signed [31:0] key,
                            input logic [6:0] index);
        bmh_cmd_t    c;
        bmh_result_t want;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge clk);
        end
        c.op = op;
        c.key = key;
        c.index = index;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        want = apply_heap_cmd(c);
        awaited_replies.push_back(want);
        ops_sent[op]++;
        statuses_seen[want.status]++;
    endtask

    // Stops offering items until the block has answered every one it took.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (awaited_replies.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Every result is matched against the oldest outstanding expectation. The
    // block cannot be stalled, so a result is sampled on the single edge that
    // ends its strobe cycle.
    always @(posedge clk)
    begin : check_replies
        bmh_result_t want;
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
            begin
                report_mismatch("result arrived with no item outstanding");
            end
            else
            begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (result.status !== want.status)
                begin
                    report_mismatch($sformatf("result %0d status: got %0d, want %0d",
                                              replies_checked, result.status,
                                              want.status));
                end
                if (result.removed_key !== want.removed_key)
                begin
                    report_mismatch($sformatf("result %0d removed_key: got %0d, want %0d",
                                              replies_checked, result.removed_key,
                                              want.removed_key));
                end
                if (result.top_key !== want.top_key)
                begin
                    report_mismatch($sformatf("result %0d top_key: got %0d, want %0d",
                                              replies_checked, result.top_key,
                                              want.top_key));
                end
                if (result.count !== want.count)
                begin
                    report_mismatch($sformatf("result %0d count: got %0d, want %0d",
                                              replies_checked, result.count,
                                              want.count));
                end
            end
        end
    end

    // Hand-picked items: every failure on an empty heap, keys at both ends of
    // the signed range, equal keys, changes that move up, down and not at all,
    // indexes at and past the count, the ignored op code, and a full drain.
    task automatic test_edge_cases();
        send_cmd(OP_REMOVE, 32'sd0, 7'd0);
        send_cmd(OP_CHANGE, 32'sd5, 7'd0);
        send_cmd(OP_IGNORED, 32'sd0, 7'd0);
        send_cmd(OP_INSERT, 32'sd0, 7'd0);
        send_cmd(OP_INSERT, 32'sh7FFF_FFFF, 7'd0);
        send_cmd(OP_INSERT, 32'sh8000_0000, 7'd0);
        send_cmd(OP_INSERT, -32'sd1, 7'd0);
        send_cmd(OP_INSERT, 32'sd7, 7'd0);
        send_cmd(OP_INSERT, 32'sd7, 7'd0);
        // The index equal to the count is the first one out of range.
        send_cmd(OP_CHANGE, 32'sd9, 7'(shadow_size));
        send_cmd(OP_CHANGE, 32'sd9, 7'd127);
        // The root drops to the minimum and must sink to a leaf.
        send_cmd(OP_CHANGE, 32'sh8000_0000, 7'd0);
        // The last leaf rises to the maximum and must climb to the root.
        send_cmd(OP_CHANGE, 32'sh7FFF_FFFF, 7'(shadow_size - 1));
        // Rewriting an entry with its own key moves nothing.
        send_cmd(OP_CHANGE, shadow_heap[2], 7'd2);
        send_cmd(OP_IGNORED, 32'sh7FFF_FFFF, 7'd127);
        while (shadow_size != 0)
        begin
            send_cmd(OP_REMOVE, $urandom(), 7'($urandom_range(127)));
        end
        send_cmd(OP_REMOVE, 32'sd0, 7'd0);
    endtask

    // Fills the heap to capacity, pushes past it, edits the root and entries at
    // the far end of the array, then drains it with changes mixed in and pulls once more.
    task automatic test_fill_to_capacity();
        while (shadow_size < CAPACITY)
        begin
            send_cmd(OP_INSERT, rand_key(), 7'($urandom_range(127)));
        end
        send_cmd(OP_INSERT, 32'sh7FFF_FFFF, 7'd0);
        send_cmd(OP_INSERT, 32'sh8000_0000, 7'd127);
        send_cmd(OP_CHANGE, 32'sh7FFF_FFFF, 7'd127);
        send_cmd(OP_CHANGE, 32'sh8000_0000, 7'd0);
        send_cmd(OP_CHANGE, rand_key(), 7'd126);
        while (shadow_size != 0)
        begin
            if ($urandom_range(7) == 0)
            begin
                send_cmd(OP_CHANGE, rand_key(), 7'($urandom_range(shadow_size - 1)));
            end
            else
            begin
                send_cmd(OP_REMOVE, rand_key(), 7'($urandom_range(127)));
            end
        end
        send_cmd(OP_REMOVE, rand_key(), 7'd0);
    endtask

    // Random traffic whose mix swings between growing and shrinking the heap.
    // Now and then the sender waits for the block to answer everything.
    task automatic test_random_traffic(input int idle_pct, input int num_items);
        bit          filling;
        int unsigned pick;
        logic [1:0]  op;
        logic [6:0]  index;
        filling = 1'b1;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < num_items; n++)
        begin
            if (shadow_size >= CAPACITY)
            begin
                filling = 1'b0;
            end
            else if (shadow_size == 0 || $urandom_range(39) == 0)
            begin
                filling = (shadow_size == 0) ? 1'b1 : !filling;
            end
            pick = $urandom_range(99);
            if (pick >= 95)
            begin
                op = OP_IGNORED;
            end
            else if (pick < (filling ? 55 : 20))
            begin
                op = OP_INSERT;
            end
            else if (pick < (filling ? 75 : 70))
            begin
                op = OP_REMOVE;
            end
            else
            begin
                op = OP_CHANGE;
            end
            // Most changes hit a live entry; the rest may fall past the count.
            if (shadow_size == 0 || $urandom_range(9) == 0)
            begin
                index = 7'($urandom_range(127));
            end
            else
            begin
                index = 7'($urandom_range(shadow_size - 1));
            end
            send_cmd(op, rand_key(), index);
            if (n % 75 == 74)
            begin
                hold_until_drained();
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_fill_to_capacity();
        hold_until_drained();

        // The sender idles rarely, then most of the time, then never.
        test_random_traffic(6, 220);
        test_random_traffic(78, 220);
        test_random_traffic(0, 220);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d items sent (%0d insert, %0d remove, %0d change, %0d ignored op)",
                 ops_sent[0] + ops_sent[1] + ops_sent[2] + ops_sent[3],
                 ops_sent[OP_INSERT], ops_sent[OP_REMOVE], ops_sent[OP_CHANGE],
                 ops_sent[OP_IGNORED]);
        $display("Summary: %0d results checked, %0d overflow, %0d underflow, %0d bad index",
                 replies_checked, statuses_seen[ST_OVERFLOW],
                 statuses_seen[ST_UNDERFLOW], statuses_seen[ST_BAD_INDEX]);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bmh_pkg.sv
hw/rtl/bmh_ram.sv
hw/rtl/binary_max_heap_priority_queue.sv
verif/tb_top.sv
